FILE: rtl/toeq_pkg.sv
// Package for the time ordered event queue: sizes, field widths, opcodes
// and the command/status structs between controller and datapath.
// No dependencies.
package toeq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 32;
   localparam int TAG_BITS    = 16;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_BITS  = 5;

   localparam int REQ_DATA_BITS = ((TIME_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = TIME_BITS + TAG_BITS + 2 + TOTAL_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int RSP_TAG_LSB     = TIME_BITS;
   localparam int RSP_REFUSED_BIT = TIME_BITS + TAG_BITS;
   localparam int RSP_EMPTY_BIT   = RSP_REFUSED_BIT + 1;
   localparam int RSP_TOTAL_LSB   = RSP_EMPTY_BIT + 1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } opcode_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic rsp_taken;
   } status_type;

endpackage

FILE: rtl/time_ordered_event_queue_top.sv
// Top level of the time ordered event queue: stream ports and packing.
// Depends on toeq_pkg, toeq_ctrl and toeq_dp.
//
// Usage: the req channel carries one command per transfer: tuser is the
// opcode (0 insert, 1 pop), tdata holds the event time and tag. The rsp
// channel returns exactly one result per command: tuser flags a popped
// event, tdata holds its time and tag (zero otherwise), the refused flag
// for an insert into a full queue, the empty flag and the entry count
// after the command.
// Timing: a command is captured at its req transfer, then applied to the
// sorted row of 16 compare-and-shift slots once the result register is free,
// and rsp_tvalid rises with that update. The two-state sequencer (capture,
// then update) takes no new command until the previous one has been applied.
// Reset empties the queue and holds req_tready low; stored slots are not
// cleared. While the receiver stalls, the result holds in its output
// register; one more command is captured and waits until that result is
// transferred.
module time_ordered_event_queue_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [toeq_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // event_time, event_tag
   input  logic                                   req_tuser,  // opcode
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_time, out_tag, insert_refused, queue_empty, entry_total, zero pad
   output logic [toeq_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                   rsp_tuser   // out_valid
);

   toeq_pkg::cmd_type                    cmd;
   toeq_pkg::status_type                 status;
   logic [toeq_pkg::TIME_BITS-1:0]       out_time;
   logic [toeq_pkg::TAG_BITS-1:0]        out_tag;
   logic                                 refused, empty;
   logic [toeq_pkg::TOTAL_BITS-1:0]      total;

   toeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   toeq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_opcode    (req_tuser),
      .req_time      (req_tdata[toeq_pkg::TIME_BITS-1:0]),
      .req_tag       (req_tdata[toeq_pkg::TIME_BITS +: toeq_pkg::TAG_BITS]),
      .rsp_out_valid (rsp_tuser),
      .rsp_time      (out_time),
      .rsp_tag       (out_tag),
      .rsp_refused   (refused),
      .rsp_empty     (empty),
      .rsp_total     (total)
   );

   assign rsp_tdata = toeq_pkg::RSP_DATA_BITS'({total, empty, refused, out_tag, out_time});

endmodule

FILE: rtl/toeq_ctrl.sv
// Controller for the time ordered event queue: two-state sequencer and
// result valid flag. Uses toeq_pkg; drives commands into toeq_dp.
module toeq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output toeq_pkg::cmd_type   cmd,
   output toeq_pkg::status_type status
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free         = !rsp_valid_ff || rsp_tready;
   assign req_tready       = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid       = rsp_valid_ff;
   assign status.rsp_taken = rsp_valid_ff && rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/toeq_dp.sv
// Datapath for the time ordered event queue: item register, sorted row of
// compare-and-shift slots, entry count and result register. Uses toeq_pkg.
module toeq_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  toeq_pkg::cmd_type                   cmd,
   input  toeq_pkg::status_type                status,
   input  logic                                req_opcode,
   input  logic [toeq_pkg::TIME_BITS-1:0]      req_time,
   input  logic [toeq_pkg::TAG_BITS-1:0]       req_tag,
   output logic                                rsp_out_valid,
   output logic [toeq_pkg::TIME_BITS-1:0]      rsp_time,
   output logic [toeq_pkg::TAG_BITS-1:0]       rsp_tag,
   output logic                                rsp_refused,
   output logic                                rsp_empty,
   output logic [toeq_pkg::TOTAL_BITS-1:0]     rsp_total
);

   localparam int DEPTH = toeq_pkg::QUEUE_DEPTH;
   localparam int CW    = toeq_pkg::COUNT_BITS;

   toeq_pkg::opcode_type                 op_ff;
   logic [toeq_pkg::TIME_BITS-1:0]       item_time_ff;
   logic [toeq_pkg::TAG_BITS-1:0]        item_tag_ff;

   logic [toeq_pkg::TIME_BITS-1:0]       time_ff [DEPTH];
   logic [toeq_pkg::TIME_BITS-1:0]       time_in [DEPTH];
   logic [toeq_pkg::TAG_BITS-1:0]        tag_ff  [DEPTH];
   logic [toeq_pkg::TAG_BITS-1:0]        tag_in  [DEPTH];
   logic [CW-1:0]                        count_ff, count_in;
   logic [DEPTH-1:0]                     le;

   logic                                 full, empty, do_insert, do_pop, store_we;

   logic                                 valid_ff, valid_in;
   logic [toeq_pkg::TIME_BITS-1:0]       otime_ff, otime_in;
   logic [toeq_pkg::TAG_BITS-1:0]        otag_ff, otag_in;
   logic                                 refused_ff, refused_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = (op_ff == toeq_pkg::OP_INSERT) && !full;
   assign do_pop    = (op_ff == toeq_pkg::OP_POP) && !empty;
   assign store_we  = cmd.execute && (do_insert || do_pop);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (count_ff > CW'(i)) && (time_ff[i] <= item_time_ff);
      end
   end

   // insert: keep earlier slots, take the new event at the first later
   // slot, shift the rest up; pop: shift everything down
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         time_in[i] = time_ff[i];
         tag_in[i]  = tag_ff[i];
         if (op_ff == toeq_pkg::OP_INSERT) begin
            if (le[i]) begin
               time_in[i] = time_ff[i];
               tag_in[i]  = tag_ff[i];
            end else if (i == 0) begin
               time_in[i] = item_time_ff;
               tag_in[i]  = item_tag_ff;
            end else if (le[i-1]) begin
               time_in[i] = item_time_ff;
               tag_in[i]  = item_tag_ff;
            end else begin
               time_in[i] = time_ff[i-1];
               tag_in[i]  = tag_ff[i-1];
            end
         end else if (i < DEPTH - 1) begin
            time_in[i] = time_ff[i+1];
            tag_in[i]  = tag_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      valid_in   = 1'b0;
      otime_in   = '0;
      otag_in    = '0;
      refused_in = 1'b0;
      unique case (op_ff)
         toeq_pkg::OP_INSERT: begin
            if (full) begin
               refused_in = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         toeq_pkg::OP_POP: begin
            if (!empty) begin
               valid_in = 1'b1;
               otime_in = time_ff[0];
               otag_in  = tag_ff[0];
               count_in = count_ff - CW'(1);
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= toeq_pkg::opcode_type'(req_opcode);
         item_time_ff <= req_time;
         item_tag_ff  <= req_tag;
      end
      if (store_we) begin
         for (int i = 0; i < DEPTH; i++) begin
            time_ff[i] <= time_in[i];
            tag_ff[i]  <= tag_in[i];
         end
      end
      if (cmd.execute) begin
         valid_ff   <= valid_in;
         otime_ff   <= otime_in;
         otag_ff    <= otag_in;
         refused_ff <= refused_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   // hold the shown count with the result: it only moves on execute, which
   // the controller issues once the previous result is free
   logic unused_taken;
   assign unused_taken = status.rsp_taken;

   assign rsp_out_valid = valid_ff && !unused_taken | valid_ff;
   assign rsp_time      = otime_ff;
   assign rsp_tag       = otag_ff;
   assign rsp_refused   = refused_ff;
   assign rsp_empty     = (count_ff == '0);
   assign rsp_total     = toeq_pkg::TOTAL_BITS'(count_ff);

endmodule

FILE: rtl/toeq_checker.sv
// Port-level checker for the time ordered event queue, bound to the top.
// Depends on toeq_pkg.
module toeq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [toeq_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [toeq_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                rsp_tuser
);

   logic                                 refused, empty;
   logic [toeq_pkg::TOTAL_BITS-1:0]      total;
   logic                                 req_xfer;

   assign refused  = rsp_tdata[toeq_pkg::RSP_REFUSED_BIT];
   assign empty    = rsp_tdata[toeq_pkg::RSP_EMPTY_BIT];
   assign total    = rsp_tdata[toeq_pkg::RSP_TOTAL_LSB +: toeq_pkg::TOTAL_BITS];
   assign req_xfer = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (empty == (total == '0)))
      else $error("empty flag disagrees with entry count");

   a_pop_not_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !refused)
      else $error("popped event also flagged refused");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> total <= toeq_pkg::TOTAL_BITS'(toeq_pkg::QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("second command taken while one is in flight");

endmodule

bind time_ordered_event_queue_top toeq_checker u_toeq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/sv/tb_time_ordered_event_queue_top.sv
// Testbench for time_ordered_event_queue_top: drives insert and pop commands with random
// gaps and stalls, predicts every response with a sorted queue model in a scoreboard.
// Depends on toeq_pkg and the RTL top level only.
module tb_time_ordered_event_queue_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      logic                                 out_valid;
      logic [toeq_pkg::TIME_BITS-1:0]       out_time;
      logic [toeq_pkg::TAG_BITS-1:0]        out_tag;
      logic                                 insert_refused;
      logic                                 queue_empty;
      logic [toeq_pkg::TOTAL_BITS-1:0]      entry_total;
   } event_result_type;

   class event_queue_scoreboard;
      logic [toeq_pkg::TIME_BITS-1:0] slot_time[$];
      logic [toeq_pkg::TAG_BITS-1:0]  slot_tag[$];
      event_result_type               expected_results[$];
      int                             error_count;

      function new();
         error_count = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_command(toeq_pkg::opcode_type op,
                                 logic [toeq_pkg::TIME_BITS-1:0] ev_time,
                                 logic [toeq_pkg::TAG_BITS-1:0] ev_tag);
         event_result_type r;
         int               pos;
         r = '0;
         if (op == toeq_pkg::OP_INSERT) begin
            if (slot_time.size() >= toeq_pkg::QUEUE_DEPTH) begin
               r.insert_refused = 1'b1;
            end else begin
               pos = 0;
               while (pos < slot_time.size() && slot_time[pos] <= ev_time) pos++;
               slot_time.insert(pos, ev_time);
               slot_tag.insert(pos, ev_tag);
            end
         end else if (slot_time.size() > 0) begin
            r.out_valid = 1'b1;
            r.out_time  = slot_time.pop_front();
            r.out_tag   = slot_tag.pop_front();
         end
         r.queue_empty = (slot_time.size() == 0);
         r.entry_total = toeq_pkg::TOTAL_BITS'(slot_time.size());
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(logic popped, logic [toeq_pkg::RSP_DATA_BITS-1:0] data);
         event_result_type want;
         if (expected_results.size() == 0) begin
            $error("response transfer with no command outstanding");
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("out_valid", want.out_valid, popped);
         compare_field("out_time", want.out_time, data[toeq_pkg::TIME_BITS-1:0]);
         compare_field("out_tag", want.out_tag,
                       data[toeq_pkg::RSP_TAG_LSB +: toeq_pkg::TAG_BITS]);
         compare_field("insert_refused", want.insert_refused,
                       data[toeq_pkg::RSP_REFUSED_BIT]);
         compare_field("queue_empty", want.queue_empty, data[toeq_pkg::RSP_EMPTY_BIT]);
         compare_field("entry_total", want.entry_total,
                       data[toeq_pkg::RSP_TOTAL_LSB +: toeq_pkg::TOTAL_BITS]);
      endfunction
   endclass

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [toeq_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [toeq_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;

   bit                       idle_enable = 1'b1;
   int                       quiet_cycles = 0;
   event_queue_scoreboard    scoreboard;

   time_ordered_event_queue_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_command(toeq_pkg::opcode_type op,
                               logic [toeq_pkg::TIME_BITS-1:0] ev_time,
                               logic [toeq_pkg::TAG_BITS-1:0] ev_tag);
      int gap;
      gap = idle_enable ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= toeq_pkg::REQ_DATA_BITS'({ev_tag, ev_time});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   function automatic logic [toeq_pkg::TIME_BITS-1:0] draw_time(int mode);
      unique case (mode)
         0: return toeq_pkg::TIME_BITS'($urandom_range(0, 7));
         1: return {{(toeq_pkg::TIME_BITS-4){1'b1}}, 4'($urandom_range(0, 15))};
         default: return toeq_pkg::TIME_BITS'($urandom);
      endcase
   endfunction

   // response side: random stall per transfer
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_enable ? $urandom_range(0, 18) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) scoreboard.check_response(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready)
            scoreboard.note_command(toeq_pkg::opcode_type'(req_tuser),
                                    req_tdata[toeq_pkg::TIME_BITS-1:0],
                                    req_tdata[toeq_pkg::TIME_BITS +: toeq_pkg::TAG_BITS]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int insert_pct;
      int time_mode;
      int phase;
      int k;
      int pct_choices[7] = '{50, 85, 15, 97, 3, 60, 40};
      scoreboard = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pop on empty, extreme times and tags, equal-time ordering, full queue
      send_command(toeq_pkg::OP_POP, 32'hDEAD_BEEF, 16'hC0DE);
      send_command(toeq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_command(toeq_pkg::OP_INSERT, 32'h0000_0000, 16'h0000);
      send_command(toeq_pkg::OP_INSERT, 32'h8000_0000, 16'h1111);
      send_command(toeq_pkg::OP_INSERT, 32'h8000_0000, 16'h2222);
      send_command(toeq_pkg::OP_INSERT, 32'h8000_0000, 16'h3333);
      send_command(toeq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h0001);
      send_command(toeq_pkg::OP_INSERT, 32'h0000_0000, 16'h8000);
      send_command(toeq_pkg::OP_INSERT, 32'h0000_0001, 16'hAAAA);
      send_command(toeq_pkg::OP_INSERT, 32'hFFFF_FFFE, 16'h5555);
      repeat (7) send_command(toeq_pkg::OP_INSERT, $urandom, 16'($urandom));
      send_command(toeq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
      repeat (7) send_command(toeq_pkg::OP_POP, $urandom, 16'($urandom));

      for (phase = 0; phase < 29; phase++) begin
         insert_pct  = pct_choices[$urandom_range(0, 6)];
         time_mode   = $urandom_range(0, 2);
         idle_enable = ($urandom_range(0, 3) != 0);
         if (phase % 7 == 3) hold_until_drained();
         for (k = 0; k < 50; k++) begin
            if ($urandom_range(0, 99) < insert_pct)
               send_command(toeq_pkg::OP_INSERT, draw_time(time_mode), 16'($urandom));
            else
               send_command(toeq_pkg::OP_POP, $urandom, 16'($urandom));
         end
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/toeq_pkg.sv
rtl/toeq_ctrl.sv
rtl/toeq_dp.sv
rtl/time_ordered_event_queue_top.sv
rtl/toeq_checker.sv
tb/sv/tb_time_ordered_event_queue_top.sv
